>>> sv/crq_pkg.sv
// ----------------------------------------------------------------------------
// crq_pkg: shared types and constants
// Defaults, field widths, request codes and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package crq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;

    localparam int SND_ID_W   = 8;
    localparam int VOLUME_W   = 8;
    localparam int PENDING_W  = 4;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct packed {
        logic shift;        // dequeue: take the upper neighbor's entry
        logic check;        // enqueue: compare and merge
        logic append_here;  // enqueue: load the new request here
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/crq_cell.sv
// ----------------------------------------------------------------------------
// crq_cell: one queue slot
// Holds an id and a volume, compares on enqueue, shifts down on dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module crq_cell #(
    parameter int ID_BITS = crq_pkg::DEF_ID_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          occupied,
    input  wire crq_pkg::cell_ctrl_t           ctrl,
    input  wire logic [ID_BITS-1:0]            req_id,
    input  wire logic [crq_pkg::VOLUME_W-1:0]  req_vol,
    input  wire logic [ID_BITS-1:0]            nbr_id,
    input  wire logic [crq_pkg::VOLUME_W-1:0]  nbr_vol,
    output logic      [ID_BITS-1:0]            id,
    output logic      [crq_pkg::VOLUME_W-1:0]  vol,
    output logic                               hit
);
    import crq_pkg::*;

    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [VOLUME_W-1:0] vol_reg, vol_next;

    assign hit = ctrl.check && occupied && (id_reg == req_id);

    always_comb
    begin
        id_next  = id_reg;
        vol_next = vol_reg;
        if (ctrl.shift)
        begin
            id_next  = nbr_id;
            vol_next = nbr_vol;
        end
        else if (ctrl.append_here)
        begin
            id_next  = req_id;
            vol_next = req_vol;
        end
        else if (hit && (req_vol > vol_reg))
        begin
            vol_next = req_vol;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        vol_reg <= vol_next;
    end

    assign id  = id_reg;
    assign vol = vol_reg;

endmodule

`default_nettype wire

>>> sv/coalescing_request_ring_queue_top.sv
// ----------------------------------------------------------------------------
// coalescing_request_ring_queue_top: coalescing play request queue
// Row of slot cells ordered from the oldest entry; merges requests by id.
// ----------------------------------------------------------------------------
// The result strobes on done the cycle after start.
// Throughput: one item per cycle; busy stays low, the parallel id compare
// across the cell row is combinational. The receiver cannot stall.
// Reset clears the entry count, the result strobe and mute; slot contents
// are undefined until written.
`default_nettype none

module coalescing_request_ring_queue_top #(
    parameter int QUEUE_DEPTH = crq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = crq_pkg::DEF_ID_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            mode,
    input  wire logic [crq_pkg::SND_ID_W-1:0]    snd_id,
    input  wire logic [crq_pkg::VOLUME_W-1:0]    volume,
    input  wire logic                            mute_we,
    input  wire logic                            mute_wdata,
    output logic                                 done,
    output logic                                 out_valid,
    output logic      [crq_pkg::SND_ID_W-1:0]    out_id,
    output logic      [crq_pkg::VOLUME_W-1:0]    out_volume,
    output logic                                 merged,
    output logic                                 dropped,
    output logic      [crq_pkg::PENDING_W-1:0]   pending_count
);
    import crq_pkg::*;

    localparam int NCELL = QUEUE_DEPTH - 1;
    localparam int CNT_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             mute_reg;
    logic             done_reg;
    logic             valid_reg, merged_reg, dropped_reg;
    logic [SND_ID_W-1:0]   id_reg;
    logic [VOLUME_W-1:0]   vol_reg;

    logic [ID_BITS-1:0]  req_id;
    logic [ID_BITS-1:0]  cell_id  [NCELL];
    logic [VOLUME_W-1:0] cell_vol [NCELL];
    logic [NCELL-1:0]    cell_hit;

    logic accept, do_deq, do_enq, any_hit, full, empty, do_append;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign req_id  = ID_BITS'(snd_id);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(NCELL));
    assign do_deq  = accept && (mode == MODE_DEQ) && !empty;
    assign do_enq  = accept && (mode == MODE_ENQ);
    assign any_hit = |cell_hit;
    assign do_append = do_enq && !any_hit && !full;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        cell_ctrl_t ctrl;
        logic       occupied;

        assign occupied         = (CNT_W'(k) < count_reg);
        assign ctrl.shift       = do_deq;
        assign ctrl.check       = do_enq;
        assign ctrl.append_here = do_append && (count_reg == CNT_W'(k));

        if (k == NCELL - 1)
        begin : g_last
            crq_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk      (clk),
                .occupied (occupied),
                .ctrl     (ctrl),
                .req_id   (req_id),
                .req_vol  (volume),
                .nbr_id   (cell_id[k]),
                .nbr_vol  (cell_vol[k]),
                .id       (cell_id[k]),
                .vol      (cell_vol[k]),
                .hit      (cell_hit[k])
            );
        end
        else
        begin : g_mid
            crq_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk      (clk),
                .occupied (occupied),
                .ctrl     (ctrl),
                .req_id   (req_id),
                .req_vol  (volume),
                .nbr_id   (cell_id[k+1]),
                .nbr_vol  (cell_vol[k+1]),
                .id       (cell_id[k]),
                .vol      (cell_vol[k]),
                .hit      (cell_hit[k])
            );
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (do_append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mute_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (mute_we)
            begin
                mute_reg <= mute_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            valid_reg   <= do_deq;
            id_reg      <= do_deq ? SND_ID_W'(cell_id[0]) : '0;
            vol_reg     <= (do_deq && !mute_reg) ? cell_vol[0] : '0;
            merged_reg  <= do_enq && any_hit;
            dropped_reg <= do_enq && !any_hit && full;
        end
    end

    assign done          = done_reg;
    assign out_valid     = valid_reg;
    assign out_id        = id_reg;
    assign out_volume    = vol_reg;
    assign merged        = merged_reg;
    assign dropped       = dropped_reg;
    assign pending_count = PENDING_W'(count_reg);

endmodule

`default_nettype wire
